// ----- rtl/stmm_pkg.sv -----
// Shared types, codes and helpers for the sparse-table range min/max engine.
// Used by stmm_cmp and the top-level core; the channel interface takes its payload types at the instance.
package stmm_pkg;

    localparam int IDX_W    = 10;
    localparam int CNT_W    = 11;
    localparam int DATA_W   = 32;
    localparam int LVL_W    = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_RANGE = 2'd1,
        STS_NOT_BUILT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_B_RDA,
        ST_B_RDB,
        ST_B_WR,
        ST_Q_BASE,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_CMB,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  entry_index;
        logic [DATA_W-1:0] max_value;
        logic [DATA_W-1:0] min_value;
        logic [IDX_W-1:0]  range_left;
        logic [IDX_W-1:0]  range_right;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]   range_max;
        logic [DATA_W-1:0]   range_min;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef logic [CNT_W-1:0] t_cfg_data;

    typedef struct packed {
        logic load;
        logic merge;
    } t_cmp_ctrl;

    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int b = 1; b < CNT_W; b++) begin
            if (v[b]) begin
                r = LVL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/stmm_chan_if.sv -----
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing; payload types come from stmm_pkg at the instance.
interface stmm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/stmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for both the max table and the min table of the engine.
module stmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/stmm_cmp.sv -----
// Shared max/min compare unit with an accumulator pair.
// Depends on stmm_pkg for the control struct.
module stmm_cmp #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  stmm_pkg::t_cmp_ctrl i_ctrl,
    input  logic [WIDTH-1:0]    i_max,
    input  logic [WIDTH-1:0]    i_min,
    output logic [WIDTH-1:0]    o_max_merged,
    output logic [WIDTH-1:0]    o_min_merged,
    output logic [WIDTH-1:0]    o_acc_max,
    output logic [WIDTH-1:0]    o_acc_min
);
    logic [WIDTH-1:0] r_acc_max;
    logic [WIDTH-1:0] r_acc_min;
    logic [WIDTH-1:0] n_acc_max;
    logic [WIDTH-1:0] n_acc_min;

    assign o_max_merged = (r_acc_max > i_max) ? r_acc_max : i_max;
    assign o_min_merged = (r_acc_min < i_min) ? r_acc_min : i_min;

    always_comb begin
        n_acc_max = r_acc_max;
        n_acc_min = r_acc_min;
        if (i_ctrl.load) begin
            n_acc_max = i_max;
            n_acc_min = i_min;
        end else if (i_ctrl.merge) begin
            n_acc_max = o_max_merged;
            n_acc_min = o_min_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_max <= n_acc_max;
        r_acc_min <= n_acc_min;
    end

    assign o_acc_max = r_acc_max;
    assign o_acc_min = r_acc_min;
endmodule

// ----- rtl/sparse_table_range_min_max_core.sv -----
// Sparse-table range maximum / range minimum engine, top level.
// Depends on stmm_pkg, stmm_chan_if, stmm_ram and stmm_cmp.
//
// One item is processed at a time and a new item is taken once the previous one
// has left its result in the output register. Both tables sit in single-read-port
// RAMs, so the two entries of a query are read one after the other and merged by
// the one shared compare unit. A build writes n - 2^j + 1 entries at every level
// j >= 1 with 2^j <= n, for a built count n; each entry takes two reads, then one
// merge and write. The tables are not cleared after reset; entries read before
// they are written return whatever the RAM holds. The count register is written
// through its own channel, which is always ready.
module sparse_table_range_min_max_core #(
    parameter int MAX_ENTRIES = 1024,
    parameter int LEVEL_COUNT = 11,
    parameter int VALUE_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stmm_chan_if.sink   i_in,
    stmm_chan_if.source o_out,
    stmm_chan_if.sink   i_cfg
);
    localparam int DEPTH    = LEVEL_COUNT * MAX_ENTRIES;
    localparam int AW       = $clog2(DEPTH);
    localparam int CNT_W    = stmm_pkg::CNT_W;
    localparam int IDX_W    = stmm_pkg::IDX_W;
    localparam int LVL_W    = stmm_pkg::LVL_W;
    localparam int DATA_W   = stmm_pkg::DATA_W;
    localparam int LevelCap = (LEVEL_COUNT >= CNT_W) ? ((1 << CNT_W) - 1)
                                                     : ((1 << LEVEL_COUNT) - 1);
    localparam int CountCap = (MAX_ENTRIES < LevelCap) ? MAX_ENTRIES : LevelCap;

    stmm_pkg::t_state    r_state;
    stmm_pkg::t_state    n_state;
    stmm_pkg::t_in_item  r_item;
    stmm_pkg::t_status   r_status;
    stmm_pkg::t_status   n_status;
    stmm_pkg::t_out_item r_out;
    stmm_pkg::t_out_item n_out;
    stmm_pkg::t_cmp_ctrl w_cmp_ctrl;

    logic [CNT_W-1:0] r_elem_count;
    logic             r_built;
    logic             n_built;
    logic [CNT_W-1:0] r_built_count;
    logic [CNT_W-1:0] n_built_count;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] n_n;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] n_i;
    logic [CNT_W-1:0] r_half;
    logic [CNT_W-1:0] n_half;
    logic [AW-1:0]    r_prev_base;
    logic [AW-1:0]    n_prev_base;
    logic [AW-1:0]    r_cur_base;
    logic [AW-1:0]    n_cur_base;
    logic [AW-1:0]    r_qbase;
    logic [AW-1:0]    n_qbase;
    logic [LVL_W-1:0] r_k;
    logic [LVL_W-1:0] n_k;
    logic [IDX_W-1:0] r_second;
    logic [IDX_W-1:0] n_second;
    logic             r_out_valid;
    logic             n_out_valid;

    logic                  w_load_ok;
    logic [CNT_W-1:0]      w_n_sat;
    logic                  w_query_bad;
    logic [CNT_W-1:0]      w_len;
    logic                  w_more_entries;
    logic                  w_more_levels;
    logic                  w_out_free;
    logic                  w_resp_fire;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [VALUE_BITS-1:0] w_wdata_max;
    logic [VALUE_BITS-1:0] w_wdata_min;
    logic [VALUE_BITS-1:0] w_rdata_max;
    logic [VALUE_BITS-1:0] w_rdata_min;
    logic [VALUE_BITS-1:0] w_merged_max;
    logic [VALUE_BITS-1:0] w_merged_min;
    logic [VALUE_BITS-1:0] w_acc_max;
    logic [VALUE_BITS-1:0] w_acc_min;

    assign w_load_ok = 32'(r_item.entry_index) < 32'(MAX_ENTRIES);
    assign w_n_sat   = (r_elem_count == '0) ? CNT_W'(1)
                     : ((32'(r_elem_count) > 32'(CountCap)) ? CNT_W'(CountCap)
                                                            : r_elem_count);
    assign w_query_bad = (r_item.range_left > r_item.range_right)
                      || (CNT_W'(r_item.range_right) >= r_built_count);
    assign w_len = CNT_W'(r_item.range_right) - CNT_W'(r_item.range_left) + CNT_W'(1);
    assign w_more_entries = ({2'b00, r_i} + 13'd1 + {1'b0, r_half, 1'b0})
                            <= {2'b00, r_n};
    assign w_more_levels  = {r_half, 2'b00} <= {2'b00, r_n};
    assign w_out_free     = !r_out_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stmm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = stmm_pkg::ST_DECODE;
                end
            end
            stmm_pkg::ST_DECODE: begin
                n_state = stmm_pkg::ST_RESP;
                unique case (r_item.operation)
                    stmm_pkg::OP_BUILD: begin
                        if (w_n_sat >= CNT_W'(2)) begin
                            n_state = stmm_pkg::ST_B_RDA;
                        end
                    end
                    stmm_pkg::OP_QUERY: begin
                        if (r_built && !w_query_bad) begin
                            n_state = stmm_pkg::ST_Q_BASE;
                        end
                    end
                    default: begin
                        n_state = stmm_pkg::ST_RESP;
                    end
                endcase
            end
            stmm_pkg::ST_B_RDA: n_state = stmm_pkg::ST_B_RDB;
            stmm_pkg::ST_B_RDB: n_state = stmm_pkg::ST_B_WR;
            stmm_pkg::ST_B_WR: begin
                if (w_more_entries || w_more_levels) begin
                    n_state = stmm_pkg::ST_B_RDA;
                end else begin
                    n_state = stmm_pkg::ST_RESP;
                end
            end
            stmm_pkg::ST_Q_BASE: n_state = stmm_pkg::ST_Q_RDA;
            stmm_pkg::ST_Q_RDA:  n_state = stmm_pkg::ST_Q_RDB;
            stmm_pkg::ST_Q_RDB:  n_state = stmm_pkg::ST_Q_CMB;
            stmm_pkg::ST_Q_CMB:  n_state = stmm_pkg::ST_RESP;
            stmm_pkg::ST_RESP: begin
                if (w_out_free) begin
                    n_state = stmm_pkg::ST_IDLE;
                end
            end
            default: n_state = stmm_pkg::ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb begin
        i_in.ready       = 1'b0;
        i_cfg.ready      = 1'b1;
        w_we             = 1'b0;
        w_waddr          = AW'(r_item.entry_index);
        w_wdata_max      = VALUE_BITS'(r_item.max_value);
        w_wdata_min      = VALUE_BITS'(r_item.min_value);
        w_raddr          = AW'(32'(r_prev_base) + 32'(r_i));
        w_cmp_ctrl.load  = 1'b0;
        w_cmp_ctrl.merge = 1'b0;
        w_resp_fire      = 1'b0;
        unique case (r_state)
            stmm_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            stmm_pkg::ST_DECODE: begin
                w_we = (r_item.operation == stmm_pkg::OP_LOAD) && w_load_ok;
            end
            stmm_pkg::ST_B_RDA: begin
                w_raddr = AW'(32'(r_prev_base) + 32'(r_i));
            end
            stmm_pkg::ST_B_RDB: begin
                w_raddr         = AW'(32'(r_prev_base) + 32'(r_i) + 32'(r_half));
                w_cmp_ctrl.load = 1'b1;
            end
            stmm_pkg::ST_B_WR: begin
                w_we        = 1'b1;
                w_waddr     = AW'(32'(r_cur_base) + 32'(r_i));
                w_wdata_max = w_merged_max;
                w_wdata_min = w_merged_min;
            end
            stmm_pkg::ST_Q_BASE: begin
                w_raddr = r_qbase;
            end
            stmm_pkg::ST_Q_RDA: begin
                w_raddr = AW'(32'(r_qbase) + 32'(r_item.range_left));
            end
            stmm_pkg::ST_Q_RDB: begin
                w_raddr         = AW'(32'(r_qbase) + 32'(r_second));
                w_cmp_ctrl.load = 1'b1;
            end
            stmm_pkg::ST_Q_CMB: begin
                w_cmp_ctrl.merge = 1'b1;
            end
            stmm_pkg::ST_RESP: begin
                w_resp_fire = w_out_free;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_status      = r_status;
        n_built       = r_built;
        n_built_count = r_built_count;
        n_n           = r_n;
        n_i           = r_i;
        n_half        = r_half;
        n_prev_base   = r_prev_base;
        n_cur_base    = r_cur_base;
        n_qbase       = r_qbase;
        n_k           = r_k;
        n_second      = r_second;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !o_out.ready;
        unique case (r_state)
            stmm_pkg::ST_DECODE: begin
                n_status = stmm_pkg::STS_OK;
                unique case (r_item.operation)
                    stmm_pkg::OP_LOAD: begin
                        if (w_load_ok) begin
                            n_built = 1'b0;
                        end else begin
                            n_status = stmm_pkg::STS_BAD_RANGE;
                        end
                    end
                    stmm_pkg::OP_BUILD: begin
                        n_n         = w_n_sat;
                        n_i         = '0;
                        n_half      = CNT_W'(1);
                        n_prev_base = '0;
                        n_cur_base  = AW'(MAX_ENTRIES);
                        if (w_n_sat < CNT_W'(2)) begin
                            n_built       = 1'b1;
                            n_built_count = w_n_sat;
                        end
                    end
                    stmm_pkg::OP_QUERY: begin
                        n_k      = stmm_pkg::floor_log2(w_len);
                        n_second = IDX_W'(CNT_W'(r_item.range_right) + CNT_W'(1)
                                   - (CNT_W'(1) << stmm_pkg::floor_log2(w_len)));
                        if (!r_built) begin
                            n_status = stmm_pkg::STS_NOT_BUILT;
                        end else if (w_query_bad) begin
                            n_status = stmm_pkg::STS_BAD_RANGE;
                        end
                    end
                    default: begin
                        n_status = stmm_pkg::STS_BAD_RANGE;
                    end
                endcase
            end
            stmm_pkg::ST_B_WR: begin
                if (w_more_entries) begin
                    n_i = r_i + CNT_W'(1);
                end else if (w_more_levels) begin
                    n_i         = '0;
                    n_half      = {r_half[CNT_W-2:0], 1'b0};
                    n_prev_base = r_cur_base;
                    n_cur_base  = AW'(32'(r_cur_base) + 32'(MAX_ENTRIES));
                end else begin
                    n_built       = 1'b1;
                    n_built_count = r_n;
                end
            end
            stmm_pkg::ST_Q_BASE: begin
                n_qbase = AW'(32'(r_k) * 32'(MAX_ENTRIES));
            end
            stmm_pkg::ST_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_status;
                    if ((r_item.operation == stmm_pkg::OP_QUERY)
                            && (r_status == stmm_pkg::STS_OK)) begin
                        n_out.range_max = DATA_W'(w_acc_max);
                        n_out.range_min = DATA_W'(w_acc_min);
                    end else begin
                        n_out.range_max = '0;
                        n_out.range_min = '0;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_out.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= stmm_pkg::ST_IDLE;
            r_elem_count  <= CNT_W'(1);
            r_built       <= 1'b0;
            r_built_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_built       <= n_built;
            r_built_count <= n_built_count;
            r_out_valid   <= n_out_valid;
            if (i_cfg.valid) begin
                r_elem_count <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
        r_status    <= n_status;
        r_n         <= n_n;
        r_i         <= n_i;
        r_half      <= n_half;
        r_prev_base <= n_prev_base;
        r_cur_base  <= n_cur_base;
        r_qbase     <= n_qbase;
        r_k         <= n_k;
        r_second    <= n_second;
        r_out       <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    stmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_max_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_max),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_max)
    );

    stmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_min_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_min),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_min)
    );

    stmm_cmp #(
        .WIDTH (VALUE_BITS)
    ) u_cmp (
        .i_clk        (i_clk),
        .i_ctrl       (w_cmp_ctrl),
        .i_max        (w_rdata_max),
        .i_min        (w_rdata_min),
        .o_max_merged (w_merged_max),
        .o_min_merged (w_merged_min),
        .o_acc_max    (w_acc_max),
        .o_acc_min    (w_acc_min)
    );

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == stmm_pkg::ST_DECODE))
        else $error("accepted item did not move to decode");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == stmm_pkg::ST_DECODE) || (r_state == stmm_pkg::ST_B_WR)))
        else $error("table write outside load or build");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status != 2'(stmm_pkg::STS_OK)))
        |-> ((o_out.data.range_max == '0) && (o_out.data.range_min == '0)))
        else $error("nonzero values with error status");

    a_built_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (r_built_count != '0))
        else $error("tables marked built with zero count");
endmodule
